// ----- hdl/tte_pkg.sv -----
// Shared constants and types for the tab to space expander.
`timescale 1ns / 1ps

package tte_pkg;

  localparam int BYTE_W          = 8;
  localparam int WIDTH_W         = 7;
  localparam int STOP_W          = 3;
  localparam int FIELD_IDX_W     = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int NUM_WIDTH_REGS  = 6;
  localparam int MAX_STOPS       = 6;
  localparam int MAX_FIELD_WIDTH = 64;
  localparam int DEFAULT_WIDTH   = 8;
  localparam int DEFAULT_STOPS   = 1;

  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_COUNT = 3'd0,
    REG_WIDTH_0    = 3'd1,
    REG_WIDTH_1    = 3'd2,
    REG_WIDTH_2    = 3'd3,
    REG_WIDTH_3    = 3'd4,
    REG_WIDTH_4    = 3'd5,
    REG_WIDTH_5    = 3'd6
  } cfg_reg_t;

endpackage

// ----- hdl/tab_to_space_expander_top.sv -----
// Tab to space expander with configurable field widths: one request in, one or more out.
`timescale 1ns / 1ps

// Each input request carries one text byte. The result register puts out one
// byte per cycle while out_stall is low. Plain bytes and newlines leave as one
// result each, so they stream at one request per cycle; a tab leaves as (field
// width - offset) spaces, 1 to MAX_FIELD_WIDTH, holds the input until its last
// space leaves, and the last space carries out_last_of_run. The line position is
// kept as a field index and an offset in the field. Register 0 sets the number
// of field widths in use, registers 1 to 6 set the widths; the last width in use
// repeats for the rest of the line. Write registers only while the block is idle.
module tab_to_space_expander_top
  import tte_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = tte_pkg::MAX_FIELD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_last_of_run,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data
);

  localparam int OFF_W = $clog2(MAX_FIELD_WIDTH);
  localparam int CNT_W = $clog2(MAX_FIELD_WIDTH + 1);
  localparam logic [WIDTH_W-1:0] MAX_W = WIDTH_W'(MAX_FIELD_WIDTH);
  localparam logic [STOP_W-1:0]  MAX_N = STOP_W'(MAX_STOPS);

  // Configuration registers
  logic [STOP_W-1:0]  stop_count_r;
  logic [WIDTH_W-1:0] width_r [NUM_WIDTH_REGS];

  // Line position
  logic [FIELD_IDX_W-1:0] field_idx_r, field_idx_nxt;
  logic [OFF_W-1:0]       offset_r, offset_nxt;

  // Work stage: output byte and number of results still to send
  logic              wrk_valid_r, wrk_valid_nxt;
  logic [BYTE_W-1:0] wrk_byte_r, wrk_byte_nxt;
  logic [CNT_W-1:0]  wrk_cnt_r, wrk_cnt_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic                   out_free;
  logic                   emit;
  logic                   emit_last;
  logic                   in_take;
  logic [STOP_W-1:0]      cnt_eff;
  logic [FIELD_IDX_W-1:0] last_f;
  logic [FIELD_IDX_W-1:0] cur_f;
  logic [FIELD_IDX_W-1:0] next_f;
  logic [WIDTH_W-1:0]     w_raw;
  logic [WIDTH_W-1:0]     w_clamp;
  logic [CNT_W-1:0]       w_cnt;
  logic [CNT_W-1:0]       off_ext;
  logic [CNT_W-1:0]       off_inc;
  logic [CNT_W-1:0]       tab_n;

  assign cfg_ready = 1'b1;

  // Handshake
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = wrk_valid_r && out_free;
  assign emit_last = emit && (wrk_cnt_r == CNT_W'(1));
  assign in_stall  = wrk_valid_r && !emit_last;
  assign in_take   = in_valid && !in_stall;

  // Current field and its width, with out-of-range settings clamped
  always_comb begin
    if (stop_count_r == '0) begin
      cnt_eff = STOP_W'(1);
    end else if (stop_count_r > MAX_N) begin
      cnt_eff = MAX_N;
    end else begin
      cnt_eff = stop_count_r;
    end
    last_f  = FIELD_IDX_W'(cnt_eff - STOP_W'(1));
    cur_f   = (field_idx_r < FIELD_IDX_W'(cnt_eff)) ? field_idx_r : last_f;
    next_f  = (cur_f < last_f) ? cur_f + FIELD_IDX_W'(1) : last_f;
    w_raw   = width_r[cur_f];
    if (w_raw == '0) begin
      w_clamp = WIDTH_W'(1);
    end else if (w_raw > MAX_W) begin
      w_clamp = MAX_W;
    end else begin
      w_clamp = w_raw;
    end
    w_cnt   = w_clamp[CNT_W-1:0];
    off_ext = CNT_W'(offset_r);
    off_inc = off_ext + CNT_W'(1);
    tab_n   = (off_ext < w_cnt) ? w_cnt - off_ext : CNT_W'(1);
  end

  // Next values of the position and the work stage
  always_comb begin
    field_idx_nxt = field_idx_r;
    offset_nxt    = offset_r;
    wrk_valid_nxt = wrk_valid_r;
    wrk_byte_nxt  = wrk_byte_r;
    wrk_cnt_nxt   = wrk_cnt_r;
    if (emit) begin
      wrk_cnt_nxt = wrk_cnt_r - CNT_W'(1);
      if (emit_last) begin
        wrk_valid_nxt = 1'b0;
      end
    end
    if (in_take) begin
      wrk_valid_nxt = 1'b1;
      if (in_byte == CH_NL) begin
        wrk_byte_nxt  = CH_NL;
        wrk_cnt_nxt   = CNT_W'(1);
        field_idx_nxt = '0;
        offset_nxt    = '0;
      end else if (in_byte == CH_TAB) begin
        wrk_byte_nxt  = CH_SPACE;
        wrk_cnt_nxt   = tab_n;
        field_idx_nxt = next_f;
        offset_nxt    = '0;
      end else begin
        wrk_byte_nxt = in_byte;
        wrk_cnt_nxt  = CNT_W'(1);
        if (off_inc >= w_cnt) begin
          field_idx_nxt = next_f;
          offset_nxt    = '0;
        end else begin
          field_idx_nxt = cur_f;
          offset_nxt    = off_inc[OFF_W-1:0];
        end
      end
    end
  end

  // Next values of the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = emit;
      out_byte_nxt  = wrk_byte_r;
      out_last_nxt  = (wrk_cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= STOP_W'(DEFAULT_STOPS);
      for (int i = 0; i < NUM_WIDTH_REGS; i++) begin
        width_r[i] <= WIDTH_W'(DEFAULT_WIDTH);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_STOP_COUNT: stop_count_r <= cfg_data[STOP_W-1:0];
        REG_WIDTH_0:    width_r[0] <= cfg_data;
        REG_WIDTH_1:    width_r[1] <= cfg_data;
        REG_WIDTH_2:    width_r[2] <= cfg_data;
        REG_WIDTH_3:    width_r[3] <= cfg_data;
        REG_WIDTH_4:    width_r[4] <= cfg_data;
        REG_WIDTH_5:    width_r[5] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_idx_r <= '0;
      offset_r    <= '0;
      wrk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      field_idx_r <= field_idx_nxt;
      offset_r    <= offset_nxt;
      wrk_valid_r <= wrk_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wrk_byte_r <= wrk_byte_nxt;
    wrk_cnt_r  <= wrk_cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

`ifndef NO_ASSERTIONS
  // Only a tab gives more than one result, and all of those are spaces.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_byte_r != CH_SPACE) |-> out_last_r)
    else $error("non-space result without end-of-run mark");

  // A pending request in the work stage always has results left to send.
  assert property (@(posedge clk) disable iff (!rst_n)
    wrk_valid_r |-> (wrk_cnt_r != '0))
    else $error("work stage holds a request with no results");

  // While a tab still has spaces beyond the next one, no new request enters.
  assert property (@(posedge clk) disable iff (!rst_n)
    wrk_valid_r && (wrk_cnt_r > CNT_W'(1)) |-> in_stall)
    else $error("input taken while a tab run is in progress");

  // The stored field index never leaves the range of supported fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    field_idx_r < FIELD_IDX_W'(MAX_STOPS))
    else $error("field index out of range");
`endif

endmodule

// ----- tb/expansion_checker.sv -----
// Checker that predicts the expanded text stream and compares it with the block's results.
`timescale 1ns / 1ps

module expansion_checker
  import tte_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [BYTE_W-1:0]    out_byte,
  input  logic                 out_last_of_run,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data,
  output int                   error_count,
  output int                   pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] text;
    logic              is_last;
  } out_char_t;

  out_char_t              expected_chars[$];
  logic [STOP_W-1:0]      stops_reg;
  logic [WIDTH_W-1:0]     width_reg[NUM_WIDTH_REGS];
  logic [FIELD_IDX_W-1:0] cur_field;
  logic [5:0]             cur_offset;
  int                     errors = 0;

  function automatic int stops_in_use();
    int n;
    n = stops_reg;
    if (n < 1) n = 1;
    if (n > MAX_STOPS) n = MAX_STOPS;
    return n;
  endfunction

  function automatic int width_of(input int f);
    int w;
    w = width_reg[f];
    if (w < 1) w = 1;
    if (w > MAX_FIELD_WIDTH) w = MAX_FIELD_WIDTH;
    return w;
  endfunction

  // The last field in use repeats once the line runs past it.
  task automatic advance_field(input int f);
    int n;
    n = stops_in_use();
    cur_field  = (f + 1 < n) ? FIELD_IDX_W'(f + 1) : FIELD_IDX_W'(n - 1);
    cur_offset = '0;
  endtask

  task automatic expand_byte(input logic [BYTE_W-1:0] c);
    int n;
    int f;
    int w;
    int off;
    n   = stops_in_use();
    f   = (cur_field < n) ? int'(cur_field) : n - 1;
    w   = width_of(f);
    off = cur_offset;
    if (c == CH_NL) begin
      expected_chars.push_back('{text: CH_NL, is_last: 1'b1});
      cur_field  = '0;
      cur_offset = '0;
    end else if (c == CH_TAB) begin
      // An offset left beyond a narrowed field counts as its last column.
      n = (off < w) ? w - off : 1;
      for (int k = 0; k < n; k++) begin
        expected_chars.push_back('{text: CH_SPACE, is_last: (k == n - 1)});
      end
      advance_field(f);
    end else begin
      expected_chars.push_back('{text: c, is_last: 1'b1});
      if (off + 1 >= w) begin
        advance_field(f);
      end else begin
        cur_field  = FIELD_IDX_W'(f);
        cur_offset = 6'(off + 1);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    if (errors < 100) $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    out_char_t want;
    if (!rst_n) begin
      stops_reg = STOP_W'(DEFAULT_STOPS);
      for (int i = 0; i < NUM_WIDTH_REGS; i++) width_reg[i] = WIDTH_W'(DEFAULT_WIDTH);
      cur_field  = '0;
      cur_offset = '0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STOP_COUNT) begin
          stops_reg = cfg_data[STOP_W-1:0];
        end else if (cfg_index <= REG_WIDTH_5) begin
          width_reg[cfg_index - REG_WIDTH_0] = cfg_data;
        end
      end
      if (in_valid && !in_stall) expand_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("result byte %h arrived with none expected", out_byte));
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.text)
            report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.text));
          if (out_last_of_run !== want.is_last)
            report_mismatch($sformatf("out_last_of_run %b, expected %b on byte %h",
                                      out_last_of_run, want.is_last, want.text));
        end
      end
    end
    error_count <= errors;
    pending     <= expected_chars.size();
  end

endmodule

// ----- tb/tab_to_space_expander_top_tb.sv -----
// Testbench top for the tab to space expander: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tab_to_space_expander_top_tb
  import tte_pkg::*;
;

  localparam int HOLDOFF_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int SETTLE_CYCLES    = 6;
  localparam int BYTES_PER_PHASE  = 63;
  localparam int DRAIN_INTERVAL   = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    out_byte;
  logic                 out_last_of_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIDTH_W-1:0]   cfg_data;

  int   error_count;
  int   pending;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles   = 0;
  int   plan_width[NUM_WIDTH_REGS];
  logic holdoff_request;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  tab_to_space_expander_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  expansion_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .pending         (pending)
  );

  // A requested hold-off stalls the result side long enough to back up the input.
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_request) begin
        holdoff_request <= 1'b0;
        out_stall       <= 1'b1;
        repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves cfg_valid high so that back-to-back writes need no second assignment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= WIDTH_W'(data);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int stops);
    write_reg(REG_STOP_COUNT, stops);
    for (int i = 0; i < NUM_WIDTH_REGS; i++) begin
      write_reg(CFG_IDX_W'(int'(REG_WIDTH_0) + i), plan_width[i]);
    end
    write_reg(REG_UNUSED, $urandom_range(0, 127));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int               r;
    logic [BYTE_W-1:0] b;
    idle_mode_t       mode;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_byte         <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_STOP_COUNT;
    cfg_data        <= '0;
    holdoff_request <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset widths: one field of eight columns that repeats.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_TAB);
    send_byte(CH_NL);
    send_byte(CH_TAB);
    send_byte("a");
    send_byte(CH_TAB);
    wait_for_results();

    // Six fields with the narrowest and widest widths, then the last one repeating.
    plan_width = '{1, 64, 2, 3, 4, 5};
    configure(6);
    send_byte(CH_TAB);
    send_byte(CH_TAB);
    send_byte("b");
    send_byte(CH_TAB);
    send_byte(CH_TAB);
    send_byte(CH_TAB);
    send_byte(CH_TAB);
    send_byte("c");
    wait_for_results();

    // Fewer fields than the current field index: the last field in use takes over.
    configure(2);
    send_byte(CH_TAB);
    send_byte("d");
    send_byte("e");
    send_byte("f");
    wait_for_results();

    // Narrow the field below the current offset, once before a tab, once before a byte.
    plan_width[1] = 2;
    configure(2);
    send_byte(CH_TAB);
    wait_for_results();
    plan_width[1] = 64;
    configure(2);
    send_byte("g");
    send_byte("h");
    send_byte("i");
    wait_for_results();
    plan_width[1] = 2;
    configure(2);
    send_byte("j");
    send_byte(CH_NL);
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      mode = idle_mode_t'(p);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          plan_width     = '{0, 127, 65, 8, 1, 64};
          configure(7);
        end
        IDLE_SENDER: begin
          send_idle_pct  = 51;
          recv_stall_pct = 0;
          plan_width[0]  = 0;
          for (int i = 1; i < NUM_WIDTH_REGS; i++) plan_width[i] = $urandom_range(1, 64);
          configure(0);
        end
        IDLE_RECEIVER: begin
          send_idle_pct  = 0;
          recv_stall_pct = 51;
          for (int i = 0; i < NUM_WIDTH_REGS; i++) plan_width[i] = $urandom_range(1, 12);
          configure($urandom_range(1, 6));
        end
        default: begin
          send_idle_pct  = 10;
          recv_stall_pct = 10;
          for (int i = 0; i < NUM_WIDTH_REGS; i++) plan_width[i] = $urandom_range(0, 127);
          configure($urandom_range(0, 7));
        end
      endcase

      for (int k = 0; k < BYTES_PER_PHASE; k++) begin
        if (mode == IDLE_NONE && k == 20) holdoff_request <= 1'b1;
        // Mostly short lines of printable text with tabs, plus some arbitrary bytes.
        r = $urandom_range(0, 99);
        if (r < 22) b = CH_TAB;
        else if (r < 30) b = CH_NL;
        else if (r < 85) b = BYTE_W'($urandom_range(32, 126));
        else b = BYTE_W'($urandom_range(0, 255));
        send_byte(b);
        if (k % DRAIN_INTERVAL == DRAIN_INTERVAL - 1) wait_for_results();
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
